>>> sv/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared constants for the rectangular to polar converter: working widths,
// gain constant and the arctangent table in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package c2p_pkg;

    localparam int WORK_BITS   = 36;   // signed working x/y, holds CORDIC growth
    localparam int PHASE_BITS  = 32;   // phase accumulator, fraction of a turn
    localparam int RADIUS_BITS = 21;
    localparam int ANGLE_BITS  = 16;
    localparam int MAX_STEPS   = 32;
    localparam int GAIN_BITS   = 28;
    localparam int LO_BITS     = 18;   // low slice of the split gain multiply
    localparam int PROD_BITS   = 64;

    localparam logic [GAIN_BITS-1:0]   GAIN_Q28   = 28'd163008219;
    localparam logic [PHASE_BITS-1:0]  HALF_TURN  = 32'h8000_0000;
    localparam logic [PHASE_BITS-1:0]  ANGLE_HALF = 32'h0000_8000;
    localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;

    localparam logic [PHASE_BITS-1:0] ATAN_TURNS [MAX_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166885,    32'd83443,     32'd41721,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

>>> sv/cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Fully unrolled CORDIC vectoring pipeline: one micro-rotation per stage,
// then a split gain multiply and a rounding/saturation stage.
// ----------------------------------------------------------------------------
// throughput: one item per cycle, busy is always low
// pipeline order: the input stage loads at the accepting edge, then one
//   stage per micro-rotation, the gain multiply stage and the output stage,
//   whose register drives done
// reset: rst_n clears all valid bits and done; no results are in flight after it
// the receiver cannot stall; every result shows for exactly one cycle on done
module cartesian_to_polar
    import c2p_pkg::*;
#(
    parameter int COORD_BITS   = 16,
    parameter int CORDIC_STEPS = 18
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  origin_x,
    input  logic signed [COORD_BITS-1:0]  origin_y,
    output logic                          done,
    output logic        [RADIUS_BITS-1:0] radius,
    output logic        [ANGLE_BITS-1:0]  angle
);

    localparam int NSTEPS    = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
    localparam int FRAC_BITS = (COORD_BITS < 32) ? 32 - COORD_BITS : 0;
    localparam int RSHIFT    = FRAC_BITS + 24;
    localparam int HI_BITS   = WORK_BITS - 1 - LO_BITS;
    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS + 23);

    // ------------------------------------------------------------------
    // input stage: difference, half-turn pre-rotation, scaling
    // ------------------------------------------------------------------
    logic signed [COORD_BITS:0]    dx;
    logic signed [COORD_BITS:0]    dy;
    logic signed [COORD_BITS:0]    dx_abs;
    logic signed [COORD_BITS:0]    dy_rot;
    logic                          flip;
    logic signed [WORK_BITS-1:0]   x0_next;
    logic signed [WORK_BITS-1:0]   y0_next;
    logic        [PHASE_BITS-1:0]  z0_next;
    logic                          zero0_next;

    assign busy = 1'b0;

    always_comb
    begin
        dx         = $signed({point_x[COORD_BITS-1], point_x})
                   - $signed({origin_x[COORD_BITS-1], origin_x});
        dy         = $signed({point_y[COORD_BITS-1], point_y})
                   - $signed({origin_y[COORD_BITS-1], origin_y});
        flip       = dx[COORD_BITS];
        dx_abs     = flip ? -dx : dx;
        dy_rot     = flip ? -dy : dy;
        zero0_next = (dx == '0) && (dy == '0);
        z0_next    = flip ? HALF_TURN : '0;
        x0_next    = $signed({{(WORK_BITS-COORD_BITS-1){dx_abs[COORD_BITS]}}, dx_abs})
                     <<< FRAC_BITS;
        y0_next    = $signed({{(WORK_BITS-COORD_BITS-1){dy_rot[COORD_BITS]}}, dy_rot})
                     <<< FRAC_BITS;
    end

    // ------------------------------------------------------------------
    // micro-rotation stages
    // ------------------------------------------------------------------
    logic signed [WORK_BITS-1:0]  x_reg     [0:NSTEPS];
    logic signed [WORK_BITS-1:0]  y_reg     [0:NSTEPS];
    logic        [PHASE_BITS-1:0] z_reg     [0:NSTEPS];
    logic                         zero_reg  [0:NSTEPS];
    logic                         valid_reg [0:NSTEPS];

    logic signed [WORK_BITS-1:0]  x_next [0:NSTEPS-1];
    logic signed [WORK_BITS-1:0]  y_next [0:NSTEPS-1];
    logic        [PHASE_BITS-1:0] z_next [0:NSTEPS-1];

    for (genvar k = 0; k < NSTEPS; k++)
    begin : g_rot
        // shifts are arithmetic, so they round toward minus infinity
        assign x_next[k] = y_reg[k][WORK_BITS-1] ? x_reg[k] - (y_reg[k] >>> k)
                                                 : x_reg[k] + (y_reg[k] >>> k);
        assign y_next[k] = y_reg[k][WORK_BITS-1] ? y_reg[k] + (x_reg[k] >>> k)
                                                 : y_reg[k] - (x_reg[k] >>> k);
        assign z_next[k] = y_reg[k][WORK_BITS-1] ? z_reg[k] - ATAN_TURNS[k]
                                                 : z_reg[k] + ATAN_TURNS[k];
    end

    // ------------------------------------------------------------------
    // gain multiply, split into two partial products
    // ------------------------------------------------------------------
    logic        [WORK_BITS-2:0]            x_clamp;
    logic        [LO_BITS+GAIN_BITS-1:0]    prod_lo_next;
    logic        [HI_BITS+GAIN_BITS-1:0]    prod_hi_next;
    logic        [ANGLE_BITS-1:0]           angle_round;
    logic        [PHASE_BITS-1:0]           z_round;

    logic        [LO_BITS+GAIN_BITS-1:0]    prod_lo_reg;
    logic        [HI_BITS+GAIN_BITS-1:0]    prod_hi_reg;
    logic        [ANGLE_BITS-1:0]           angle_mul_reg;
    logic                                   zero_mul_reg;
    logic                                   valid_mul_reg;

    always_comb
    begin
        x_clamp      = x_reg[NSTEPS][WORK_BITS-1] ? '0 : x_reg[NSTEPS][WORK_BITS-2:0];
        prod_lo_next = (LO_BITS+GAIN_BITS)'(x_clamp[LO_BITS-1:0])
                     * (LO_BITS+GAIN_BITS)'(GAIN_Q28);
        prod_hi_next = (HI_BITS+GAIN_BITS)'(x_clamp[WORK_BITS-2:LO_BITS])
                     * (HI_BITS+GAIN_BITS)'(GAIN_Q28);
        z_round      = z_reg[NSTEPS] + ANGLE_HALF;
        angle_round  = z_round[PHASE_BITS-1 -: ANGLE_BITS];
    end

    // ------------------------------------------------------------------
    // sum, round, shift, saturate
    // ------------------------------------------------------------------
    logic [PROD_BITS-1:0]   prod_sum;
    logic [PROD_BITS-1:0]   prod_shift;
    logic [RADIUS_BITS-1:0] radius_next;
    logic [ANGLE_BITS-1:0]  angle_next;

    logic                   done_reg;
    logic [RADIUS_BITS-1:0] radius_reg;
    logic [ANGLE_BITS-1:0]  angle_reg;

    always_comb
    begin
        prod_sum   = (PROD_BITS'(prod_hi_reg) << LO_BITS) + PROD_BITS'(prod_lo_reg)
                   + ROUND_HALF;
        prod_shift = prod_sum >> RSHIFT;
        if (prod_shift[PROD_BITS-1:RADIUS_BITS] != '0)
            radius_next = RADIUS_MAX;
        else
            radius_next = prod_shift[RADIUS_BITS-1:0];
        // zero vector gives radius 0 and angle 0
        if (zero_mul_reg)
        begin
            radius_next = '0;
            angle_next  = '0;
        end
        else
        begin
            angle_next  = angle_mul_reg;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSTEPS; k++)
                valid_reg[k] <= 1'b0;
            valid_mul_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= start && !busy;
            for (int k = 0; k < NSTEPS; k++)
                valid_reg[k+1] <= valid_reg[k];
            valid_mul_reg <= valid_reg[NSTEPS];
            done_reg      <= valid_mul_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        zero_reg[0] <= zero0_next;
        for (int k = 0; k < NSTEPS; k++)
        begin
            x_reg[k+1]    <= x_next[k];
            y_reg[k+1]    <= y_next[k];
            z_reg[k+1]    <= z_next[k];
            zero_reg[k+1] <= zero_reg[k];
        end
        prod_lo_reg   <= prod_lo_next;
        prod_hi_reg   <= prod_hi_next;
        angle_mul_reg <= angle_round;
        zero_mul_reg  <= zero_reg[NSTEPS];
        radius_reg    <= radius_next;
        angle_reg     <= angle_next;
    end

    assign done   = done_reg;
    assign radius = radius_reg;
    assign angle  = angle_reg;

endmodule
